/* rtl/core/btw_alu_pkg.sv */
package btw_alu_pkg;

	// fixed field widths
	localparam int WORD_W      = 12;
	localparam int JUMP_W      = 10;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int WORD_TRITS  = WORD_W / 2;
	localparam int TRITS_DEF   = 6;

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
	localparam logic [OP_W-1:0] OP_INC  = 3'd1;
	localparam logic [OP_W-1:0] OP_NEG  = 3'd2;
	localparam logic [OP_W-1:0] OP_SIGN = 3'd3;
	localparam logic [OP_W-1:0] OP_JUMP = 3'd4;
	localparam logic [OP_W-1:0] OP_PASS = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_FINE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

	// trit as a 2-bit signed value, same bits as its code
	localparam logic signed [1:0] TRIT_POS  = 2'sb01;
	localparam logic signed [1:0] TRIT_ZERO = 2'sb00;
	localparam logic signed [1:0] TRIT_NEG  = 2'sb11;

	// word in flight through the cell row
	typedef struct packed {
		logic                vld;
		logic [OP_W-1:0]     op;
		logic [WORD_W-1:0]   acc;
		logic [WORD_W-1:0]   opd;
		logic [WORD_W-1:0]   res;
		logic signed [1:0]   carry;
		logic signed [1:0]   sgn;
		logic [JUMP_W-1:0]   jmp;
	} btw_lane_t;

	// unused code 10 reads as zero
	function automatic logic signed [1:0] trit_of(input logic [1:0] code);
		logic signed [1:0] t;
		t = (code == 2'b10) ? TRIT_ZERO : signed'(code);
		return t;
	endfunction

	// 3^n modulo 2^JUMP_W, elaboration only
	function automatic logic [JUMP_W-1:0] pow3_mod(input int n);
		logic [JUMP_W-1:0] p;
		p = JUMP_W'(1);
		for (int i = 0; i < n; i++) begin
			p = JUMP_W'(p * 3);
		end
		return p;
	endfunction

endpackage

/* rtl/core/balanced_ternary_word_alu.sv */
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+-----------------------
// command   | operation, accumulator_word, operand_word      | start & !busy
// result    | result_word, status, skip_taken, jump_address  | done, one cycle
//
// one word per clock; busy stays low, so every start is taken
// a word passes through the cell row, one trit per cell,
// and its result shows with done as it leaves the last cell's register
// arst_n clears every register of the row
// the receiver cannot stall: each result is shown for exactly one cycle
module balanced_ternary_word_alu import btw_alu_pkg::*; #(
	parameter int TRITS_PER_WORD = TRITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     operation,
	input  logic [WORD_W-1:0]   accumulator_word,
	input  logic [WORD_W-1:0]   operand_word,
	output logic                done,
	output logic [WORD_W-1:0]   result_word,
	output logic [STATUS_W-1:0] status,
	output logic                skip_taken,
	output logic [JUMP_W-1:0]   jump_address
);

	// lane[k] feeds cell k, lane[TRITS_PER_WORD] is the last cell's register
	btw_lane_t lane [0:TRITS_PER_WORD];
	btw_lane_t last;

	// row never holds off a word
	assign busy = 1'b0;

	// entry of the row; increment is an add with carry in of +1
	assign lane[0] = '{
		vld:   start,
		op:    operation,
		acc:   accumulator_word,
		opd:   operand_word,
		res:   WORD_W'(0),
		carry: (operation == OP_INC) ? TRIT_POS : TRIT_ZERO,
		sgn:   TRIT_ZERO,
		jmp:   JUMP_W'(0)
	};

	// one cell per trit, carry and partial fields ripple one cell per cycle
	for (genvar k = 0; k < TRITS_PER_WORD; k++) begin : g_cell
		btw_alu_cell #(
			.IDX(k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.lane_i (lane[k]),
			.lane_q (lane[k+1])
		);
	end

	assign last = lane[TRITS_PER_WORD];
	assign done = last.vld;

	// pick the fields the operation defines, the rest read zero
	always_comb begin
		result_word  = '0;
		status       = ST_FINE;
		skip_taken   = 1'b0;
		jump_address = '0;
		if (last.vld) begin
			unique case (last.op)
				OP_ADD, OP_INC: begin
					result_word = last.res;
					// carry past the top trit is dropped and flagged
					if (last.carry == TRIT_POS) begin
						status = ST_OVER;
					end else if (last.carry == TRIT_NEG) begin
						status = ST_UNDER;
					end else begin
						status = ST_FINE;
					end
				end
				OP_NEG: begin
					result_word = last.res;
				end
				OP_SIGN: begin
					// sign follows the highest nonzero trit
					skip_taken = (last.sgn != TRIT_NEG);
				end
				OP_JUMP: begin
					jump_address = last.jmp;
				end
				OP_PASS: begin
					// copied bit for bit, unused codes included
					result_word = last.acc;
				end
				default: begin
					result_word = '0;
				end
			endcase
		end
	end

endmodule

/* rtl/core/btw_alu_cell.sv */
module btw_alu_cell import btw_alu_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  btw_lane_t lane_i,
	output btw_lane_t lane_q
);

	localparam logic [JUMP_W-1:0] P3 = pow3_mod(IDX);

	logic signed [1:0] acc_trit;
	logic signed [1:0] opd_trit;
	logic signed [1:0] add_a;
	logic signed [1:0] add_b;
	logic signed [2:0] sum;
	logic signed [2:0] sum_fix;
	logic signed [1:0] carry_nxt;
	logic signed [1:0] res_trit;
	logic [JUMP_W-1:0] jmp_add;
	btw_lane_t         nxt;

	// trits beyond the word read as zero
	assign acc_trit = trit_of(2'(lane_i.acc >> (2 * IDX)));
	assign opd_trit = trit_of(2'(lane_i.opd >> (2 * IDX)));

	assign add_a = (lane_i.op == OP_ADD) ? acc_trit : opd_trit;
	assign add_b = (lane_i.op == OP_ADD) ? opd_trit : TRIT_ZERO;
	assign sum   = add_a + add_b + lane_i.carry;

	always_comb begin
		if (sum > 3'sd1) begin
			sum_fix   = sum - 3'sd3;
			carry_nxt = TRIT_POS;
		end else if (sum < -3'sd1) begin
			sum_fix   = sum + 3'sd3;
			carry_nxt = TRIT_NEG;
		end else begin
			sum_fix   = sum;
			carry_nxt = TRIT_ZERO;
		end
	end

	assign res_trit = (lane_i.op == OP_NEG) ? -opd_trit : sum_fix[1:0];

	// (trit + 1) * 3^IDX toward 364 + value
	always_comb begin
		if (opd_trit == TRIT_POS) begin
			jmp_add = JUMP_W'(P3 << 1);
		end else if (opd_trit == TRIT_ZERO) begin
			jmp_add = P3;
		end else begin
			jmp_add = '0;
		end
	end

	always_comb begin
		nxt       = lane_i;
		nxt.res   = (lane_i.res & ~(WORD_W'(3) << (2 * IDX)))
			| ({{(WORD_W-2){1'b0}}, res_trit} << (2 * IDX));
		nxt.carry = carry_nxt;
		nxt.sgn   = (opd_trit != TRIT_ZERO) ? opd_trit : lane_i.sgn;
		nxt.jmp   = lane_i.jmp + jmp_add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
		end else begin
			lane_q <= nxt;
		end
	end

endmodule

/* rtl/core/btw_alu_chk.sv */
module btw_alu_chk #(
	parameter int TRITS_PER_WORD = 6
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [11:0] result_word,
	input logic [1:0]  status,
	input logic        skip_taken,
	input logic [9:0]  jump_address
);

	// every result traces back to a word that was taken at the row's entry
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TRITS_PER_WORD))
		else $error("result without matching command");

	// result fields stay quiet between results
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (result_word == 12'd0 && status == 2'd0 && !skip_taken
			&& jump_address == 10'd0))
		else $error("result fields active without done");

	// a jump address never comes with other result fields
	a_jump_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(jump_address != 10'd0) |-> (result_word == 12'd0 && status == 2'd0
			&& !skip_taken))
		else $error("jump address mixed with other fields");

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		status != 2'd3)
		else $error("bad status code");

endmodule

bind balanced_ternary_word_alu btw_alu_chk #(
	.TRITS_PER_WORD(TRITS_PER_WORD)
) u_btw_alu_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_word  (result_word),
	.status       (status),
	.skip_taken   (skip_taken),
	.jump_address (jump_address)
);

/* test/balanced_ternary_word_alu_tb.sv */
module balanced_ternary_word_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import btw_alu_pkg::*;

	// trits per word, same as the instance below
	localparam int NTRITS       = TRITS_DEF;
	// the cell row holds one register per trit
	localparam int LATENCY      = NTRITS;
	localparam int DRAIN_CYCLES = 2 * LATENCY + 8;
	// watchdog limit, above the longest legal quiet stretch (longest gap between words plus the row latency)
	localparam int IDLE_LIMIT   = 400;
	localparam int GAP_MAX      = 19;
	localparam int RANDOM_WORDS = 500;

	// operation codes the block does not define
	localparam logic [OP_W-1:0] OP_RSV6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSV7 = 3'd7;

	// trit codes, two bits each
	localparam logic [1:0] CODE_ZERO = 2'b00;
	localparam logic [1:0] CODE_POS  = 2'b01;
	localparam logic [1:0] CODE_BAD  = 2'b10;
	localparam logic [1:0] CODE_NEG  = 2'b11;

	// whole words of one code
	localparam logic [WORD_W-1:0] WORD_ALL_POS = 12'h555;
	localparam logic [WORD_W-1:0] WORD_ALL_NEG = 12'hFFF;
	localparam logic [WORD_W-1:0] WORD_ALL_BAD = 12'hAAA;

	// one command word waiting for the driver, with the pause that follows it
	typedef struct {
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] opd;
		int unsigned       gap;
	} alu_cmd_t;

	// everything the block shows with done
	typedef struct {
		logic [WORD_W-1:0]   res;
		logic [STATUS_W-1:0] st;
		logic                skip;
		logic [JUMP_W-1:0]   jmp;
	} alu_outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [OP_W-1:0]     operation = OP_ADD;
	logic [WORD_W-1:0]   accumulator_word = '0;
	logic [WORD_W-1:0]   operand_word = '0;
	logic                done;
	logic [WORD_W-1:0]   result_word;
	logic [STATUS_W-1:0] status;
	logic                skip_taken;
	logic [JUMP_W-1:0]   jump_address;

	alu_cmd_t     cmd_q[$];          // words not yet handed to the block
	alu_outcome_t outcome_q[$];      // results owed by the block, oldest first
	bit           word_taken = 1'b0; // start & !busy seen at the last rising edge
	int unsigned  gap_left = 0;
	bit           no_idle = 1'b0;    // stretch of back-to-back words
	int unsigned  idle_cycles = 0;
	int unsigned  mismatches = 0;
	int unsigned  words_in = 0;
	int unsigned  results_seen = 0;
	int unsigned  op_count[8];
	int unsigned  status_count[4];

	balanced_ternary_word_alu #(
		.TRITS_PER_WORD(NTRITS)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.accumulator_word (accumulator_word),
		.operand_word     (operand_word),
		.done             (done),
		.result_word      (result_word),
		.status           (status),
		.skip_taken       (skip_taken),
		.jump_address     (jump_address)
	);

	always #6 clk = ~clk;

	// signed value of trit i; code 10 and trits above the word read as zero
	function automatic int trit_value(logic [WORD_W-1:0] w, int i);
		logic [1:0] code;
		if (i >= WORD_TRITS)
			return 0;
		code = w[2*i +: 2];
		case (code)
			CODE_POS: return 1;
			CODE_NEG: return -1;
			default:  return 0;
		endcase
	endfunction

	function automatic logic [1:0] trit_code(int t);
		if (t > 0)
			return CODE_POS;
		if (t < 0)
			return CODE_NEG;
		return CODE_ZERO;
	endfunction

	function automatic longint word_value(logic [WORD_W-1:0] w);
		longint v;
		longint p;
		v = 0;
		p = 1;
		for (int i = 0; i < NTRITS; i++) begin
			v += trit_value(w, i) * p;
			p *= 3;
		end
		return v;
	endfunction

	// what the block must answer for one command word
	function automatic alu_outcome_t compute_outcome(logic [OP_W-1:0] op,
			logic [WORD_W-1:0] acc, logic [WORD_W-1:0] opd);
		alu_outcome_t o;
		int           carry;
		int           s;
		longint       half;
		o.res = '0;
		o.st = ST_FINE;
		o.skip = 1'b0;
		o.jmp = '0;
		case (op)
			OP_ADD, OP_INC: begin
				// increment is the operand plus a carry into trit 0
				carry = (op == OP_INC) ? 1 : 0;
				for (int i = 0; i < NTRITS; i++) begin
					s = carry + trit_value(opd, i) + ((op == OP_ADD) ? trit_value(acc, i) : 0);
					if (s > 1) begin
						s -= 3;
						carry = 1;
					end else if (s < -1) begin
						s += 3;
						carry = -1;
					end else begin
						carry = 0;
					end
					if (i < WORD_TRITS)
						o.res[2*i +: 2] = trit_code(s);
				end
				// carry out of the top trit is dropped and flagged
				if (carry > 0)
					o.st = ST_OVER;
				else if (carry < 0)
					o.st = ST_UNDER;
			end
			OP_NEG: begin
				for (int i = 0; i < NTRITS && i < WORD_TRITS; i++)
					o.res[2*i +: 2] = trit_code(-trit_value(opd, i));
			end
			OP_SIGN: begin
				o.skip = (word_value(opd) >= 0);
			end
			OP_JUMP: begin
				half = 1;
				for (int i = 0; i < NTRITS; i++)
					half *= 3;
				half = (half - 1) / 2;
				o.jmp = JUMP_W'(half + word_value(opd));
			end
			OP_PASS: begin
				// bit copy, bad codes included
				o.res = acc;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// mix of raw bit patterns, clean trit words, words near the ends and sparse words
	function automatic logic [WORD_W-1:0] random_word();
		logic [WORD_W-1:0] w;
		int                kind;
		int                idx;
		kind = $urandom_range(0, 9);
		w = WORD_W'($urandom);
		if (kind < 4) begin
			// clean codes only: turn every 10 into 11
			for (int i = 0; i < WORD_TRITS; i++)
				if (w[2*i+1])
					w[2*i] = 1'b1;
		end else if (kind < 6) begin
			w = $urandom_range(0, 1) ? WORD_ALL_POS : WORD_ALL_NEG;
			idx = $urandom_range(0, WORD_TRITS - 1);
			w[2*idx +: 2] = trit_code(int'($urandom_range(0, 2)) - 1);
		end else if (kind < 7) begin
			w = '0;
			idx = $urandom_range(0, WORD_TRITS - 1);
			w[2*idx +: 2] = $urandom_range(0, 1) ? CODE_POS : CODE_NEG;
		end
		return w;
	endfunction

	task automatic queue_cmd(logic [OP_W-1:0] op, logic [WORD_W-1:0] acc,
			logic [WORD_W-1:0] opd);
		alu_cmd_t c;
		// now and then switch between idling and back-to-back stretches
		if ($urandom_range(0, 24) == 0)
			no_idle = !no_idle;
		c.op = op;
		c.acc = acc;
		c.opd = opd;
		c.gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
		cmd_q.push_back(c);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("%0t ns: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// driver: payload and start change on the falling edge; a word is held until taken
	always @(negedge clk) begin
		alu_cmd_t c;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || word_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				c = cmd_q.pop_front();
				operation <= c.op;
				accumulator_word <= c.acc;
				operand_word <= c.opd;
				start <= 1'b1;
				gap_left = c.gap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: take words and results at the rising edge, check in order
	always @(posedge clk) begin
		alu_outcome_t want;
		if (arst_n) begin
			word_taken = start && !busy;
			if (word_taken) begin
				outcome_q.push_back(compute_outcome(operation, accumulator_word, operand_word));
				words_in++;
				op_count[operation]++;
			end
			if (done) begin
				results_seen++;
				status_count[status]++;
				if (outcome_q.size() == 0) begin
					report_mismatch("done with no word in flight", 1, 0);
				end else begin
					want = outcome_q.pop_front();
					if (result_word !== want.res)
						report_mismatch("result_word", result_word, want.res);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (skip_taken !== want.skip)
						report_mismatch("skip_taken", skip_taken, want.skip);
					if (jump_address !== want.jmp)
						report_mismatch("jump_address", jump_address, want.jmp);
				end
			end
			// watchdog: nothing moving on either side for too long
			if (word_taken || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no word or result for %0d cycles", $realtime, IDLE_LIMIT);
				$display("** balanced_ternary_word_alu: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		// directed words: ends of the range, every operation, bad codes, unknown codes
		queue_cmd(OP_ADD, '0, '0);
		queue_cmd(OP_ADD, WORD_ALL_POS, WORD_ALL_POS);   // overflow
		queue_cmd(OP_ADD, WORD_ALL_NEG, WORD_ALL_NEG);   // underflow
		queue_cmd(OP_ADD, WORD_ALL_POS, WORD_ALL_NEG);   // cancels to zero
		queue_cmd(OP_ADD, WORD_ALL_BAD, 12'h001);        // bad codes read as zero
		queue_cmd(OP_INC, '0, WORD_ALL_POS);             // ripples out of the top
		queue_cmd(OP_INC, WORD_ALL_POS, WORD_ALL_NEG);
		queue_cmd(OP_INC, '0, WORD_ALL_BAD);
		queue_cmd(OP_NEG, '0, WORD_ALL_POS);
		queue_cmd(OP_NEG, '0, WORD_ALL_BAD);             // comes out all clean zeros
		queue_cmd(OP_NEG, WORD_ALL_NEG, 12'h9E4);
		queue_cmd(OP_SIGN, '0, '0);                      // zero counts as non-negative
		queue_cmd(OP_SIGN, '0, WORD_ALL_NEG);
		queue_cmd(OP_SIGN, '0, 12'h3FF);                 // negative below a zero top trit
		queue_cmd(OP_SIGN, '0, 12'h7FF);                 // positive top trit wins
		queue_cmd(OP_SIGN, '0, WORD_ALL_BAD);
		queue_cmd(OP_JUMP, '0, WORD_ALL_POS);            // highest address
		queue_cmd(OP_JUMP, '0, WORD_ALL_NEG);            // address zero
		queue_cmd(OP_JUMP, WORD_ALL_POS, '0);            // middle of the range
		queue_cmd(OP_PASS, WORD_ALL_BAD, WORD_ALL_POS);  // bad codes pass untouched
		queue_cmd(OP_PASS, WORD_ALL_NEG, '0);
		queue_cmd(OP_RSV6, WORD_ALL_POS, WORD_ALL_NEG);
		queue_cmd(OP_RSV7, WORD_ALL_NEG, WORD_ALL_POS);

		// random words, mostly defined operations
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 19) == 0)
				queue_cmd($urandom_range(0, 1) ? OP_RSV6 : OP_RSV7, random_word(), random_word());
			else
				queue_cmd(OP_W'($urandom_range(OP_ADD, OP_PASS)), random_word(), random_word());
		end

		// reset released on a falling edge, away from the rising edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || outcome_q.size() != 0)
			@(negedge clk);
		// let any stray done show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words: add %0d, inc %0d, neg %0d, sign %0d, jump %0d, pass %0d, other %0d",
			words_in, op_count[OP_ADD], op_count[OP_INC], op_count[OP_NEG], op_count[OP_SIGN],
			op_count[OP_JUMP], op_count[OP_PASS], op_count[OP_RSV6] + op_count[OP_RSV7]);
		$display("%0d results checked, %0d overflow, %0d underflow, %0d mismatches",
			results_seen, status_count[ST_OVER], status_count[ST_UNDER], mismatches);
		if (mismatches == 0)
			$display("** balanced_ternary_word_alu: PASSED **");
		else
			$display("** balanced_ternary_word_alu: FAILED **");
		$finish;
	end

endmodule

/* balanced_ternary_word_alu.f */
rtl/core/btw_alu_pkg.sv
rtl/core/btw_alu_cell.sv
rtl/core/balanced_ternary_word_alu.sv
rtl/core/btw_alu_chk.sv
test/balanced_ternary_word_alu_tb.sv
